### sv/slt_pkg.sv
// slt_pkg: shared types, field widths and codes for the sequential list table
`timescale 1ns / 1ps

package slt_pkg;

    localparam int DEF_CAPACITY = 128;

    localparam int REQ_W   = 3;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 8;
    localparam int IN_W    = 240;
    localparam int OUT_W   = 248;

    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FIND   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_POS  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [7:0]  age;
        logic [23:0] name2;
        logic [63:0] name1;
        logic [63:0] name0;
        logic [63:0] key_low;
        logic [7:0]  key_high;
    } t_rec;

endpackage

### sv/sequential_list_table_top.sv
// sequential_list_table_top: ordered record list kept in one synchronous memory
//
// Requests arrive as beats on the slave stream: tuser carries the request type,
// tdata the position, key, name and age. Each request gives exactly one result
// beat on the master stream: tuser carries the status, tdata the position read
// or found, the record read or found (zero otherwise) and the entry count.
// Records live in a CAPACITY x 232 bit memory with a registered read; the table
// takes one request at a time and drops tready until its result is in the output register.
// The memory port walks one entry per cycle during a shift or a key search.
// A finished result waits in an output register while the next request is
// taken; if the receiver stalls longer, the following result is held back.
// Synchronous reset empties the list at once; memory contents are not cleared.
module sequential_list_table_top #(
    parameter int CAPACITY = slt_pkg::DEF_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // position, key_high, key_low, name_part0, name_part1, name_part2, age_in
    input  logic [slt_pkg::IN_W-1:0]    s_axis_tdata,
    // req_type
    input  logic [slt_pkg::REQ_W-1:0]   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // found_position, rd_key_high, rd_key_low, rd_name0, rd_name1, rd_name2,
    // rd_age, entry_count
    output logic [slt_pkg::OUT_W-1:0]   m_axis_tdata,
    // status
    output logic [slt_pkg::STAT_W-1:0]  m_axis_tuser
);
    import slt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UP   = 3'd1;
    localparam logic [2:0] S_PUT  = 3'd2;
    localparam logic [2:0] S_DN   = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_FIND = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    t_rec r_mem [CAPACITY];
    t_rec r_rdata;

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_addr, n_addr;
    logic [POS_W-1:0]  r_pos, n_pos;
    t_rec              r_rec, n_rec;
    logic [STAT_W-1:0] r_p_status, n_p_status;
    logic [POS_W-1:0]  r_p_fpos, n_p_fpos;
    t_rec              r_p_rec, n_p_rec;
    logic              r_m_valid, n_m_valid;
    logic [STAT_W-1:0] r_m_status, n_m_status;
    logic [POS_W-1:0]  r_m_fpos, n_m_fpos;
    t_rec              r_m_rec, n_m_rec;
    logic [POS_W-1:0]  r_m_count, n_m_count;

    logic              w_re, w_we;
    logic [AW-1:0]     w_raddr, w_waddr;
    t_rec              w_wdata;

    logic [POS_W-1:0]  w_in_pos;
    t_rec              w_in_rec;
    logic [PW-1:0]     w_in_pos_x, w_pos_x, w_cnt_x, w_fpos_x;
    logic              w_full, w_accept, w_key_hit;
    logic [AW-1:0]     w_last_addr, w_ins_addr;

    assign w_in_pos         = s_axis_tdata[7:0];
    assign w_in_rec.key_high = s_axis_tdata[15:8];
    assign w_in_rec.key_low  = s_axis_tdata[79:16];
    assign w_in_rec.name0    = s_axis_tdata[143:80];
    assign w_in_rec.name1    = s_axis_tdata[207:144];
    assign w_in_rec.name2    = s_axis_tdata[231:208];
    assign w_in_rec.age      = s_axis_tdata[239:232];

    assign w_in_pos_x  = PW'(w_in_pos);
    assign w_pos_x     = PW'(r_pos);
    assign w_cnt_x     = PW'(r_count);
    assign w_fpos_x    = PW'(r_addr) + PW'(1);
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_last_addr = AW'(w_cnt_x - PW'(1));
    assign w_ins_addr  = AW'(w_pos_x - PW'(1));
    assign w_key_hit   = (r_rdata.key_high == r_rec.key_high) &&
                         (r_rdata.key_low == r_rec.key_low);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_addr     = r_addr;
        n_pos      = r_pos;
        n_rec      = r_rec;
        n_p_status = r_p_status;
        n_p_fpos   = r_p_fpos;
        n_p_rec    = r_p_rec;
        w_re       = 1'b0;
        w_raddr    = r_addr;
        w_we       = 1'b0;
        w_waddr    = r_addr;
        w_wdata    = r_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_pos      = w_in_pos;
                    n_rec      = w_in_rec;
                    n_p_status = ST_OK;
                    n_p_fpos   = '0;
                    n_p_rec    = '0;
                    n_state    = S_DONE;
                    unique case (s_axis_tuser)
                        REQ_APPEND: begin
                            if (w_full) begin
                                n_p_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = AW'(w_cnt_x);
                                w_wdata = w_in_rec;
                                n_count = r_count + CW'(1);
                            end
                        end
                        REQ_INSERT: begin
                            if (w_full) begin
                                n_p_status = ST_FULL;
                            end else if (w_in_pos_x == '0 ||
                                         w_in_pos_x > w_cnt_x + PW'(1)) begin
                                n_p_status = ST_BAD_POS;
                            end else if (w_in_pos_x == w_cnt_x + PW'(1)) begin
                                w_we    = 1'b1;
                                w_waddr = AW'(w_cnt_x);
                                w_wdata = w_in_rec;
                                n_count = r_count + CW'(1);
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = w_last_addr;
                                n_addr  = w_last_addr;
                                n_state = S_UP;
                            end
                        end
                        REQ_DELETE: begin
                            if (w_in_pos_x == '0 || w_in_pos_x > w_cnt_x) begin
                                n_p_status = ST_BAD_POS;
                            end else if (w_in_pos_x == w_cnt_x) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = AW'(w_in_pos_x);
                                n_addr  = AW'(w_in_pos_x);
                                n_state = S_DN;
                            end
                        end
                        REQ_READ: begin
                            if (w_in_pos_x == '0 || w_in_pos_x > w_cnt_x) begin
                                n_p_status = ST_BAD_POS;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = AW'(w_in_pos_x - PW'(1));
                                n_state = S_RD;
                            end
                        end
                        REQ_FIND: begin
                            if (r_count == '0) begin
                                n_p_status = ST_NOT_FOUND;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = '0;
                                n_addr  = '0;
                                n_state = S_FIND;
                            end
                        end
                        default: begin
                            n_p_status = ST_OK;
                        end
                    endcase
                end
            end
            S_UP: begin
                w_we    = 1'b1;
                w_waddr = r_addr + AW'(1);
                w_wdata = r_rdata;
                if (r_addr == w_ins_addr) begin
                    n_state = S_PUT;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_addr - AW'(1);
                    n_addr  = r_addr - AW'(1);
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = w_ins_addr;
                w_wdata = r_rec;
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end
            S_DN: begin
                w_we    = 1'b1;
                w_waddr = r_addr - AW'(1);
                w_wdata = r_rdata;
                if (r_addr == w_last_addr) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_addr + AW'(1);
                    n_addr  = r_addr + AW'(1);
                end
            end
            S_RD: begin
                n_p_fpos = r_pos;
                n_p_rec  = r_rdata;
                n_state  = S_DONE;
            end
            S_FIND: begin
                if (w_key_hit) begin
                    n_p_fpos = w_fpos_x[POS_W-1:0];
                    n_p_rec  = r_rdata;
                    n_state  = S_DONE;
                end else if (r_addr == w_last_addr) begin
                    n_p_status = ST_NOT_FOUND;
                    n_state    = S_DONE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_addr + AW'(1);
                    n_addr  = r_addr + AW'(1);
                end
            end
            S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register, refilled from the staged result
    always_comb begin
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_status = r_m_status;
        n_m_fpos   = r_m_fpos;
        n_m_rec    = r_m_rec;
        n_m_count  = r_m_count;
        if (r_state == S_DONE && (!r_m_valid || m_axis_tready)) begin
            n_m_valid  = 1'b1;
            n_m_status = r_p_status;
            n_m_fpos   = r_p_fpos;
            n_m_rec    = r_p_rec;
            n_m_count  = w_cnt_x[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
        end
        r_addr     <= n_addr;
        r_pos      <= n_pos;
        r_rec      <= n_rec;
        r_p_status <= n_p_status;
        r_p_fpos   <= n_p_fpos;
        r_p_rec    <= n_p_rec;
        r_m_status <= n_m_status;
        r_m_fpos   <= n_m_fpos;
        r_m_rec    <= n_m_rec;
        r_m_count  <= n_m_count;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {r_m_count, r_m_rec.age, r_m_rec.name2, r_m_rec.name1,
                            r_m_rec.name0, r_m_rec.key_low, r_m_rec.key_high, r_m_fpos};

endmodule
